/* hdl/triangle_mesh_quality_cost_unit_assert.svh */
// assertion macros for the triangle mesh quality cost unit checker
// expects clk and rst_n in the scope of each use
`ifndef TRIANGLE_MESH_QUALITY_COST_UNIT_ASSERT_SVH
`define TRIANGLE_MESH_QUALITY_COST_UNIT_ASSERT_SVH

// next-cycle implication, off while reset is asserted
`define TMQC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmqc: check failed");

// next-cycle implication that also runs through reset
`define TMQC_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tmqc: reset check failed");

`endif

/* hdl/tmqc_pkg.sv */
// shared types, constants and the blend table builder for the mesh quality cost unit
// no dependencies
package tmqc_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int TANH_ENTRIES = 256;
  localparam int IDX_W        = $clog2(TANH_ENTRIES);
  localparam int BLEND_W      = 30;
  localparam int SUM_W        = 48;
  localparam int DIV_STEPS    = 16;
  localparam int DCNT_W       = $clog2(DIV_STEPS);

  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [32:0] RATIO_K  = 33'd7439101574;
  localparam logic [31:0] COST_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] COST_ONE = 32'd1 << FRAC_BITS;

  typedef logic [4:0] op_t;

  localparam op_t OP_NOP   = 5'd0;
  localparam op_t OP_LOAD  = 5'd1;
  localparam op_t OP_MA    = 5'd2;
  localparam op_t OP_MB    = 5'd3;
  localparam op_t OP_JSIGN = 5'd4;
  localparam op_t OP_ONE   = 5'd5;
  localparam op_t OP_NEGM  = 5'd6;
  localparam op_t OP_NEGSQ = 5'd7;
  localparam op_t OP_P1    = 5'd8;
  localparam op_t OP_P2    = 5'd9;
  localparam op_t OP_T1    = 5'd10;
  localparam op_t OP_T2    = 5'd11;
  localparam op_t OP_T3    = 5'd12;
  localparam op_t OP_T4    = 5'd13;
  localparam op_t OP_NORM  = 5'd14;
  localparam op_t OP_RKLO  = 5'd15;
  localparam op_t OP_RKHI  = 5'd16;
  localparam op_t OP_DINIT = 5'd17;
  localparam op_t OP_DSTEP = 5'd18;
  localparam op_t OP_RATIO = 5'd19;
  localparam op_t OP_PCOST = 5'd20;
  localparam op_t OP_ACC   = 5'd21;
  localparam op_t OP_EMAX  = 5'd22;
  localparam op_t OP_AINIT = 5'd23;
  localparam op_t OP_BL1   = 5'd24;
  localparam op_t OP_BL2   = 5'd25;

  typedef struct packed {
    logic j_zero;
    logic j_neg;
    logic norm_done;
    logic div_last;
    logic max_big;
    logic last;
  } status_t;

  typedef logic [TANH_ENTRIES-1:0][BLEND_W-1:0] blend_tab_t;

  // unsigned quotient by shift and subtract, only evaluated while building the table
  function automatic logic [63:0] cdiv(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= 65'(den)) begin
        rem    = rem - 65'(den);
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-f in Q30, truncated series
  function automatic logic [63:0] exp_frac(logic [63:0] f);
    longint      sum;
    logic [63:0] term;
    sum  = longint'(Q30_ONE);
    term = 64'(Q30_ONE);
    for (int n = 1; n <= 16; n++) begin
      term = cdiv((term * f) >> 30, 64'(n));
      if ((n & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  function automatic logic [63:0] exp_neg(logic [63:0] z);
    logic [63:0] k;
    logic [63:0] e;
    logic [63:0] e1;
    k  = z >> 30;
    e  = exp_frac(z & (64'(Q30_ONE) - 64'd1));
    e1 = exp_frac(64'(Q30_ONE));
    for (longint j = 0; j < longint'(k); j++) begin
      e = (e * e1) >> 30;
    end
    return e;
  endfunction

  // blend factor 0.5*(tanh(5(c-1))+1) in Q30 over c in [0, 1]
  function automatic blend_tab_t build_blend();
    blend_tab_t  tab;
    logic [63:0] den;
    logic [63:0] steps;
    logic [63:0] z;
    logic [63:0] e;
    den = 64'(TANH_ENTRIES - 1);
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      steps  = den - 64'(i);
      z      = cdiv(64'd10 * steps * 64'(Q30_ONE), den);
      e      = exp_neg(z);
      tab[i] = BLEND_W'(cdiv(e << 30, 64'(Q30_ONE) + e));
    end
    return tab;
  endfunction

endpackage

/* hdl/tmqc_dp.sv */
// datapath: edge vectors, jacobian, condition number ratio, shared multiplier,
// 2-bit restoring divider, node accumulators and output registers; uses tmqc_pkg
module tmqc_dp #(
  parameter int MAX_TRIANGLES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tmqc_pkg::op_t      op,
  input  logic signed [31:0] in_corner0_x,
  input  logic signed [31:0] in_corner0_y,
  input  logic signed [31:0] in_corner1_x,
  input  logic signed [31:0] in_corner1_y,
  input  logic signed [31:0] in_corner2_x,
  input  logic signed [31:0] in_corner2_y,
  input  logic               in_last_triangle,
  output tmqc_pkg::status_t  sts,
  output logic [31:0]        out_node_cost,
  output logic               out_cost_saturated
);

  localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
  localparam int IP_W  = 32 + tmqc_pkg::IDX_W + 1;
  localparam int F     = tmqc_pkg::FRAC_BITS;
  localparam tmqc_pkg::blend_tab_t BLEND_TAB = tmqc_pkg::build_blend();

  // index 0 ux, 1 uy, 2 vx, 3 vy
  logic [31:0] mag_r [4];
  logic [3:0]  neg_r;
  logic [28:0] sm_r [4];
  logic [30:0] wm_r [2];
  logic        last_r;
  logic [63:0] ma_r, mb_r, jmag_r, ts_r, num_r;
  logic signed [59:0] js_r;
  logic [58:0] jn_r;
  logic [29:0] jnc_r;
  logic [31:0] den_r, rem_r, nlo_r, quo_r;
  logic        ovf_r;
  logic [tmqc_pkg::DCNT_W-1:0] dcnt_r;
  logic [30:0] d_r;
  logic [31:0] m_r, cost_r, avg_r, diff_r;
  logic        tri_sat_r;
  logic [tmqc_pkg::BLEND_W-1:0] b_r;
  logic [31:0] max_cost_r;
  logic [tmqc_pkg::SUM_W-1:0] cost_sum_r;
  logic [CNT_W-1:0] count_r;
  logic        sat_seen_r;
  logic [31:0] out_cost_r;
  logic        out_sat_r;

  // edge vectors
  logic signed [32:0] dif [4];
  assign dif[0] = 33'(in_corner2_x) - 33'(in_corner1_x);
  assign dif[1] = 33'(in_corner2_y) - 33'(in_corner1_y);
  assign dif[2] = 33'(in_corner0_x) - 33'(in_corner1_x);
  assign dif[3] = 33'(in_corner0_y) - 33'(in_corner1_y);

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // jacobian sign and magnitude
  logic        na, nb, jneg_c;
  logic [64:0] jsum;
  logic [63:0] jmag_c;

  // scaling
  logic [31:0] m01, m23, mx;
  logic [1:0]  sh;

  // scaled signed values and w vector
  logic [31:0] sx [4];
  logic [31:0] wx, wy;

  // negative jacobian
  logic [64:0] msum, mfull;
  logic [63:0] csq;

  // ratio clamp
  logic [29:0] jnc_c;
  logic [30:0] r_c;

  // divider
  logic [31:0] dinit_num_hi, dinit_num_lo, dinit_den;
  logic [32:0] t1, t2;
  logic        ge1, ge2;
  logic [31:0] r1, r2;

  // accumulate and blend
  logic [tmqc_pkg::SUM_W:0] sum_c;
  logic [IP_W-1:0] ip, isft;
  logic [tmqc_pkg::IDX_W-1:0] idx;
  logic [31:0] avg_c;

  always_comb begin
    unique case (op)
      tmqc_pkg::OP_MA:    begin mul_a = mag_r[0];         mul_b = mag_r[3];         end
      tmqc_pkg::OP_MB:    begin mul_a = mag_r[1];         mul_b = mag_r[2];         end
      tmqc_pkg::OP_NEGSQ: begin mul_a = m_r;              mul_b = m_r;              end
      tmqc_pkg::OP_P1:    begin mul_a = 32'(sm_r[0]);     mul_b = 32'(sm_r[3]);     end
      tmqc_pkg::OP_P2:    begin mul_a = 32'(sm_r[1]);     mul_b = 32'(sm_r[2]);     end
      tmqc_pkg::OP_T1:    begin mul_a = 32'(sm_r[0]);     mul_b = 32'(sm_r[0]);     end
      tmqc_pkg::OP_T2:    begin mul_a = 32'(sm_r[1]);     mul_b = 32'(sm_r[1]);     end
      tmqc_pkg::OP_T3:    begin mul_a = 32'(wm_r[0]);     mul_b = 32'(wm_r[0]);     end
      tmqc_pkg::OP_T4:    begin mul_a = 32'(wm_r[1]);     mul_b = 32'(wm_r[1]);     end
      tmqc_pkg::OP_RKLO:  begin mul_a = 32'(jnc_c);       mul_b = tmqc_pkg::RATIO_K[31:0]; end
      tmqc_pkg::OP_PCOST: begin mul_a = 32'(d_r);         mul_b = 32'(d_r);         end
      tmqc_pkg::OP_BL2:   begin mul_a = 32'(b_r);         mul_b = diff_r;           end
      default:            begin mul_a = 32'd0;            mul_b = 32'd0;            end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    na   = (ma_r != 64'd0) && (neg_r[0] != neg_r[3]);
    nb   = (mb_r != 64'd0) && (neg_r[1] == neg_r[2]);
    jsum = {1'b0, ma_r} + {1'b0, mb_r};
    if (na == nb) begin
      jmag_c = jsum[64] ? '1 : jsum[63:0];
      jneg_c = na;
    end else if (ma_r >= mb_r) begin
      jmag_c = ma_r - mb_r;
      jneg_c = na;
    end else begin
      jmag_c = mb_r - ma_r;
      jneg_c = nb;
    end

    m01 = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    m23 = (mag_r[2] > mag_r[3]) ? mag_r[2] : mag_r[3];
    mx  = (m01 > m23) ? m01 : m23;
    priority if (mx[31:29] == 3'b000) sh = 2'd0;
    else if (mx[31:30] == 2'b00)      sh = 2'd1;
    else if (!mx[31])                 sh = 2'd2;
    else                              sh = 2'd3;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sx[i] = neg_r[i] ? (32'd0 - 32'(sm_r[i])) : 32'(sm_r[i]);
    end
    wx = (sx[2] << 1) - sx[0];
    wy = (sx[3] << 1) - sx[1];
  end

  always_comb begin
    msum  = {1'b0, jmag_r} + (65'd1 << (2 * F));
    mfull = msum >> F;
    csq   = prod >> F;
    jnc_c = ({5'd0, jn_r} > ts_r) ? ts_r[29:0] : jn_r[29:0];
    priority if (jnc_r == 30'd0)         r_c = 31'd0;
    else if (ovf_r)                      r_c = tmqc_pkg::Q30_ONE;
    else if (quo_r > 32'(tmqc_pkg::Q30_ONE)) r_c = tmqc_pkg::Q30_ONE;
    else                                 r_c = quo_r[30:0];
  end

  // divider init source and two quotient bits per cycle
  always_comb begin
    if (op == tmqc_pkg::OP_AINIT) begin
      dinit_num_hi = 32'(cost_sum_r >> 32);
      dinit_num_lo = cost_sum_r[31:0];
      dinit_den    = (count_r == '0) ? 32'd1 : 32'(count_r);
    end else begin
      dinit_num_hi = num_r[63:32];
      dinit_num_lo = num_r[31:0];
      dinit_den    = ts_r[31:0];
    end
    t1  = {rem_r, nlo_r[31]};
    ge1 = t1 >= {1'b0, den_r};
    r1  = ge1 ? 32'(t1 - {1'b0, den_r}) : t1[31:0];
    t2  = {r1, nlo_r[30]};
    ge2 = t2 >= {1'b0, den_r};
    r2  = ge2 ? 32'(t2 - {1'b0, den_r}) : t2[31:0];
  end

  always_comb begin
    sum_c = {1'b0, cost_sum_r} + (tmqc_pkg::SUM_W + 1)'(cost_r);
    ip    = IP_W'(max_cost_r) * IP_W'(tmqc_pkg::TANH_ENTRIES - 1) + (IP_W'(1) << (F - 1));
    isft  = ip >> F;
    idx   = (isft >= IP_W'(tmqc_pkg::TANH_ENTRIES)) ?
            tmqc_pkg::IDX_W'(tmqc_pkg::TANH_ENTRIES - 1) : isft[tmqc_pkg::IDX_W-1:0];
    if (ovf_r || (quo_r > max_cost_r)) avg_c = max_cost_r;
    else                               avg_c = quo_r;
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (op)
      tmqc_pkg::OP_LOAD: begin
        for (int i = 0; i < 4; i++) begin
          mag_r[i] <= dif[i][32] ? 32'(-dif[i]) : 32'(dif[i]);
          neg_r[i] <= dif[i][32];
        end
        last_r    <= in_last_triangle;
        tri_sat_r <= 1'b0;
      end
      tmqc_pkg::OP_MA: ma_r <= prod;
      tmqc_pkg::OP_MB: mb_r <= prod;
      tmqc_pkg::OP_JSIGN: begin
        jmag_r <= jmag_c;
        for (int i = 0; i < 4; i++) sm_r[i] <= 29'(mag_r[i] >> sh);
      end
      tmqc_pkg::OP_ONE: cost_r <= tmqc_pkg::COST_ONE;
      tmqc_pkg::OP_NEGM: begin
        m_r       <= mfull[31:0];
        tri_sat_r <= jmag_r[63] | (|mfull[64:32]);
      end
      tmqc_pkg::OP_NEGSQ: begin
        if (tri_sat_r || (|csq[63:32])) begin
          cost_r    <= tmqc_pkg::COST_MAX;
          tri_sat_r <= 1'b1;
        end else begin
          cost_r <= csq[31:0];
        end
      end
      tmqc_pkg::OP_P1: begin
        js_r    <= (neg_r[0] ^ neg_r[3]) ? -$signed(prod[59:0]) : $signed(prod[59:0]);
        wm_r[0] <= wx[31] ? 31'(-wx) : wx[30:0];
        wm_r[1] <= wy[31] ? 31'(-wy) : wy[30:0];
      end
      tmqc_pkg::OP_P2: begin
        js_r <= (neg_r[1] ^ neg_r[2]) ? js_r + $signed(prod[59:0])
                                      : js_r - $signed(prod[59:0]);
      end
      tmqc_pkg::OP_T1: ts_r <= prod;
      tmqc_pkg::OP_T2: ts_r <= ts_r + prod;
      tmqc_pkg::OP_T3: ts_r <= (ts_r << 1) + ts_r + prod;
      tmqc_pkg::OP_T4: begin
        ts_r <= ts_r + prod;
        jn_r <= (js_r > 60'sd0) ? js_r[58:0] : 59'd0;
      end
      tmqc_pkg::OP_NORM: begin
        // coarse steps while far above the limit, then single halvings
        if (|ts_r[63:38]) begin
          ts_r <= ts_r >> 8;
          jn_r <= jn_r >> 8;
        end else if (|ts_r[63:30]) begin
          ts_r <= ts_r >> 1;
          jn_r <= jn_r >> 1;
        end
      end
      tmqc_pkg::OP_RKLO: begin
        jnc_r <= jnc_c;
        num_r <= prod;
      end
      tmqc_pkg::OP_RKHI: begin
        num_r <= num_r + (tmqc_pkg::RATIO_K[32] ? {2'b00, jnc_r, 32'd0} : 64'd0);
      end
      tmqc_pkg::OP_DINIT, tmqc_pkg::OP_AINIT: begin
        den_r  <= dinit_den;
        ovf_r  <= dinit_num_hi >= dinit_den;
        rem_r  <= dinit_num_hi;
        nlo_r  <= dinit_num_lo;
        quo_r  <= 32'd0;
        dcnt_r <= '0;
      end
      tmqc_pkg::OP_DSTEP: begin
        rem_r  <= r2;
        nlo_r  <= nlo_r << 2;
        quo_r  <= {quo_r[29:0], ge1, ge2};
        dcnt_r <= dcnt_r + 1'b1;
      end
      tmqc_pkg::OP_RATIO: d_r <= tmqc_pkg::Q30_ONE - r_c;
      tmqc_pkg::OP_PCOST: cost_r <= 32'(prod >> (60 - F));
      tmqc_pkg::OP_BL1: begin
        avg_r  <= avg_c;
        diff_r <= max_cost_r - avg_c;
        b_r    <= BLEND_TAB[idx];
      end
      default: ;
    endcase
  end

  // node accumulators and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cost_r <= 32'd0;
      cost_sum_r <= '0;
      count_r    <= '0;
      sat_seen_r <= 1'b0;
    end else begin
      unique case (op)
        tmqc_pkg::OP_ACC: begin
          if (count_r < CNT_W'(MAX_TRIANGLES)) begin
            count_r <= count_r + 1'b1;
            if (cost_r > max_cost_r) max_cost_r <= cost_r;
            cost_sum_r <= sum_c[tmqc_pkg::SUM_W] ? '1 : sum_c[tmqc_pkg::SUM_W-1:0];
            sat_seen_r <= sat_seen_r | tri_sat_r | sum_c[tmqc_pkg::SUM_W];
          end else begin
            sat_seen_r <= 1'b1;
          end
        end
        tmqc_pkg::OP_EMAX, tmqc_pkg::OP_BL2: begin
          max_cost_r <= 32'd0;
          cost_sum_r <= '0;
          count_r    <= '0;
          sat_seen_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      tmqc_pkg::OP_EMAX: begin
        out_cost_r <= max_cost_r;
        out_sat_r  <= sat_seen_r;
      end
      tmqc_pkg::OP_BL2: begin
        out_cost_r <= avg_r + 32'(prod >> 30);
        out_sat_r  <= sat_seen_r;
      end
      default: ;
    endcase
  end

  assign sts.j_zero    = (jmag_c == 64'd0);
  assign sts.j_neg     = jneg_c;
  assign sts.norm_done = ~|ts_r[63:30];
  assign sts.div_last  = (dcnt_r == tmqc_pkg::DCNT_W'(tmqc_pkg::DIV_STEPS - 1));
  assign sts.max_big   = max_cost_r > tmqc_pkg::COST_ONE;
  assign sts.last      = last_r;

  assign out_node_cost      = out_cost_r;
  assign out_cost_saturated = out_sat_r;

endmodule

/* hdl/tmqc_ctrl.sv */
// controller: sequences datapath operations per triangle and per node result
// uses tmqc_pkg for operation codes and status
module tmqc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tmqc_pkg::status_t sts,
  output tmqc_pkg::op_t     op
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MA    = 5'd1;
  localparam logic [4:0] S_MB    = 5'd2;
  localparam logic [4:0] S_JS    = 5'd3;
  localparam logic [4:0] S_ONE   = 5'd4;
  localparam logic [4:0] S_NEGM  = 5'd5;
  localparam logic [4:0] S_NEGSQ = 5'd6;
  localparam logic [4:0] S_P1    = 5'd7;
  localparam logic [4:0] S_P2    = 5'd8;
  localparam logic [4:0] S_T1    = 5'd9;
  localparam logic [4:0] S_T2    = 5'd10;
  localparam logic [4:0] S_T3    = 5'd11;
  localparam logic [4:0] S_T4    = 5'd12;
  localparam logic [4:0] S_NORM  = 5'd13;
  localparam logic [4:0] S_RKLO  = 5'd14;
  localparam logic [4:0] S_RKHI  = 5'd15;
  localparam logic [4:0] S_DINIT = 5'd16;
  localparam logic [4:0] S_DSTEP = 5'd17;
  localparam logic [4:0] S_RATIO = 5'd18;
  localparam logic [4:0] S_PCOST = 5'd19;
  localparam logic [4:0] S_ACC   = 5'd20;
  localparam logic [4:0] S_FIN   = 5'd21;
  localparam logic [4:0] S_EMAX  = 5'd22;
  localparam logic [4:0] S_AINIT = 5'd23;
  localparam logic [4:0] S_ASTEP = 5'd24;
  localparam logic [4:0] S_BL1   = 5'd25;
  localparam logic [4:0] S_BL2   = 5'd26;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free, emit;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    op        = tmqc_pkg::OP_NOP;
    emit      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = tmqc_pkg::OP_LOAD;
          state_nxt = S_MA;
        end
      end
      S_MA:    begin op = tmqc_pkg::OP_MA; state_nxt = S_MB; end
      S_MB:    begin op = tmqc_pkg::OP_MB; state_nxt = S_JS; end
      S_JS: begin
        op = tmqc_pkg::OP_JSIGN;
        priority if (sts.j_zero) state_nxt = S_ONE;
        else if (sts.j_neg)      state_nxt = S_NEGM;
        else                     state_nxt = S_P1;
      end
      S_ONE:   begin op = tmqc_pkg::OP_ONE;   state_nxt = S_ACC;   end
      S_NEGM:  begin op = tmqc_pkg::OP_NEGM;  state_nxt = S_NEGSQ; end
      S_NEGSQ: begin op = tmqc_pkg::OP_NEGSQ; state_nxt = S_ACC;   end
      S_P1:    begin op = tmqc_pkg::OP_P1;    state_nxt = S_P2;    end
      S_P2:    begin op = tmqc_pkg::OP_P2;    state_nxt = S_T1;    end
      S_T1:    begin op = tmqc_pkg::OP_T1;    state_nxt = S_T2;    end
      S_T2:    begin op = tmqc_pkg::OP_T2;    state_nxt = S_T3;    end
      S_T3:    begin op = tmqc_pkg::OP_T3;    state_nxt = S_T4;    end
      S_T4:    begin op = tmqc_pkg::OP_T4;    state_nxt = S_NORM;  end
      S_NORM: begin
        op = tmqc_pkg::OP_NORM;
        if (sts.norm_done) state_nxt = S_RKLO;
      end
      S_RKLO:  begin op = tmqc_pkg::OP_RKLO;  state_nxt = S_RKHI;  end
      S_RKHI:  begin op = tmqc_pkg::OP_RKHI;  state_nxt = S_DINIT; end
      S_DINIT: begin op = tmqc_pkg::OP_DINIT; state_nxt = S_DSTEP; end
      S_DSTEP: begin
        op = tmqc_pkg::OP_DSTEP;
        if (sts.div_last) state_nxt = S_RATIO;
      end
      S_RATIO: begin op = tmqc_pkg::OP_RATIO; state_nxt = S_PCOST; end
      S_PCOST: begin op = tmqc_pkg::OP_PCOST; state_nxt = S_ACC;   end
      S_ACC: begin
        op        = tmqc_pkg::OP_ACC;
        state_nxt = sts.last ? S_FIN : S_IDLE;
      end
      S_FIN: state_nxt = sts.max_big ? S_EMAX : S_AINIT;
      S_EMAX: begin
        if (out_free) begin
          op        = tmqc_pkg::OP_EMAX;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_AINIT: begin op = tmqc_pkg::OP_AINIT; state_nxt = S_ASTEP; end
      S_ASTEP: begin
        op = tmqc_pkg::OP_DSTEP;
        if (sts.div_last) state_nxt = S_BL1;
      end
      S_BL1: begin op = tmqc_pkg::OP_BL1; state_nxt = S_BL2; end
      S_BL2: begin
        if (out_free) begin
          op        = tmqc_pkg::OP_BL2;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (emit)  out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hdl/triangle_mesh_quality_cost_unit.sv */
// top level of the triangle mesh quality cost unit: controller plus datapath
// depends on tmqc_pkg, tmqc_ctrl, tmqc_dp
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | in_corner{0,1,2}_{x,y}, in_last_triangle
//   out     | out_valid/ out_ready | out_node_cost, out_cost_saturated
//
// a triangle with positive area passes through the shared 32x32 multiplier, the
// normalize loop and the 2-bit restoring divider
// negative and zero area triangles skip the normalize loop and the divider
// a node's last triangle adds the result, plus a divide when the average is blended
// reset is synchronous; a stalled result waits in the output register while the
// next item is taken, and only the following result waits for it
module triangle_mesh_quality_cost_unit #(
  parameter int MAX_TRIANGLES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_corner0_x,
  input  logic signed [31:0] in_corner0_y,
  input  logic signed [31:0] in_corner1_x,
  input  logic signed [31:0] in_corner1_y,
  input  logic signed [31:0] in_corner2_x,
  input  logic signed [31:0] in_corner2_y,
  input  logic               in_last_triangle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_node_cost,
  output logic               out_cost_saturated
);

  tmqc_pkg::op_t     op;
  tmqc_pkg::status_t sts;

  tmqc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .op        (op)
  );

  tmqc_dp #(
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .in_corner0_x       (in_corner0_x),
    .in_corner0_y       (in_corner0_y),
    .in_corner1_x       (in_corner1_x),
    .in_corner1_y       (in_corner1_y),
    .in_corner2_x       (in_corner2_x),
    .in_corner2_y       (in_corner2_y),
    .in_last_triangle   (in_last_triangle),
    .sts                (sts),
    .out_node_cost      (out_node_cost),
    .out_cost_saturated (out_cost_saturated)
  );

endmodule

/* hdl/tmqc_checker.sv */
// port-level checker for the triangle mesh quality cost unit, bound to the top level
// depends on triangle_mesh_quality_cost_unit_assert.svh
`include "triangle_mesh_quality_cost_unit_assert.svh"

module tmqc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_node_cost,
  input logic        out_cost_saturated
);

  // a stalled result holds
  `TMQC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_node_cost) && $stable(out_cost_saturated))

  // one item at a time: busy right after an accept
  `TMQC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // reset leaves the block idle with no result pending
  `TMQC_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_valid && in_ready)

endmodule

bind triangle_mesh_quality_cost_unit tmqc_checker u_tmqc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_node_cost      (out_node_cost),
  .out_cost_saturated (out_cost_saturated)
);

/* tb/tb_top.sv */
// testbench for the triangle mesh quality cost unit: drives triangles, predicts node costs
// depends on tmqc_pkg and triangle_mesh_quality_cost_unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // triangle limit of one node, as on the block
  localparam int NODE_LIMIT = 65536;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] ONE30 = 64'd1 << 30;
  localparam logic [63:0] RATIO = 64'd7439101574;

  typedef struct packed {
    logic              drain;
    logic              last;
    logic [5:0][31:0]  xy;   // c0x c0y c1x c1y c2x c2y, index 0 is c0x
  } tri_item_t;

  typedef struct packed {
    logic [31:0] cost;
    logic        sat;
  } node_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_corner0_x, in_corner0_y, in_corner1_x;
  logic signed [31:0] in_corner1_y, in_corner2_x, in_corner2_y;
  logic in_last_triangle;
  logic out_valid;
  logic out_ready;
  logic [31:0] out_node_cost;
  logic out_cost_saturated;

  tri_item_t    tri_q[$];
  tri_item_t    cur_tri;
  node_result_t node_cost_q[$];
  logic [63:0]  blend_lut[tmqc_pkg::TANH_ENTRIES];
  logic [63:0]  node_max, node_sum, node_count;
  logic         node_sat;
  int           n_accepted;
  int           n_errors;
  int           idle_cycles;
  bit           stim_done;

  triangle_mesh_quality_cost_unit #(.MAX_TRIANGLES(NODE_LIMIT)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_corner0_x(in_corner0_x), .in_corner0_y(in_corner0_y),
    .in_corner1_x(in_corner1_x), .in_corner1_y(in_corner1_y),
    .in_corner2_x(in_corner2_x), .in_corner2_y(in_corner2_y),
    .in_last_triangle(in_last_triangle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_node_cost(out_node_cost), .out_cost_saturated(out_cost_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // e^-f in Q30 by a series truncated after the f^16 term
  function automatic logic [63:0] series_exp(logic [63:0] f);
    longint      acc;
    logic [63:0] term;
    acc  = longint'(ONE30);
    term = ONE30;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * f) >> 30) / 64'(n);
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  function automatic void fill_blend_lut();
    logic [63:0] den, z, e, e1, k;
    den = 64'(tmqc_pkg::TANH_ENTRIES - 1);
    e1  = series_exp(ONE30);
    for (int i = 0; i < tmqc_pkg::TANH_ENTRIES; i++) begin
      z = (64'd10 * (den - 64'(i)) * ONE30) / den;
      k = z >> 30;
      e = series_exp(z & (ONE30 - 64'd1));
      for (int j = 0; j < int'(k); j++) e = (e * e1) >> 30;
      blend_lut[i] = (e << 30) / (ONE30 + e);
    end
  endfunction

  function automatic logic [63:0] mag(longint d);
    return (d < 0) ? 64'(-d) : 64'(d);
  endfunction

  function automatic longint shrink_toward_zero(longint d, int s);
    longint m;
    m = longint'(mag(d) >> s);
    return (d < 0) ? -m : m;
  endfunction

  function automatic logic [63:0] triangle_cost(logic [5:0][31:0] xy, output logic sat);
    longint      ux, uy, vx, vy, uxs, uys, vxs, vys, js, wx, wy;
    logic [63:0] ma, mb, jmag, m, c, mx, ts, jn, r, d;
    logic [64:0] wide;
    logic        na, nb, jneg;
    int          s;
    ux = longint'($signed(xy[4])) - longint'($signed(xy[2]));
    uy = longint'($signed(xy[5])) - longint'($signed(xy[3]));
    vx = longint'($signed(xy[0])) - longint'($signed(xy[2]));
    vy = longint'($signed(xy[1])) - longint'($signed(xy[3]));
    ma = mag(ux) * mag(vy);
    mb = mag(uy) * mag(vx);
    na = (ma != 0) && ((ux < 0) != (vy < 0));
    nb = (mb != 0) && ((uy < 0) == (vx < 0));
    sat = 1'b0;
    if (na == nb) begin
      wide = 65'(ma) + 65'(mb);
      jmag = wide[64] ? '1 : wide[63:0];
      jneg = na;
    end else if (ma >= mb) begin
      jmag = ma - mb;
      jneg = na;
    end else begin
      jmag = mb - ma;
      jneg = nb;
    end
    if (jmag == 0) return 64'(tmqc_pkg::COST_ONE);
    if (jneg) begin
      if (jmag[63]) begin
        sat = 1'b1;
        return 64'(tmqc_pkg::COST_MAX);
      end
      m = ((64'd1 << (2 * tmqc_pkg::FRAC_BITS)) + jmag) >> tmqc_pkg::FRAC_BITS;
      if (m >= (64'd1 << 32)) begin
        sat = 1'b1;
        return 64'(tmqc_pkg::COST_MAX);
      end
      c = (m * m) >> tmqc_pkg::FRAC_BITS;
      if (c > 64'(tmqc_pkg::COST_MAX)) begin
        sat = 1'b1;
        return 64'(tmqc_pkg::COST_MAX);
      end
      return c;
    end
    mx = mag(ux);
    if (mag(uy) > mx) mx = mag(uy);
    if (mag(vx) > mx) mx = mag(vx);
    if (mag(vy) > mx) mx = mag(vy);
    s = 0;
    while (s < 40 && (mx >> s) >= (64'd1 << 29)) s++;
    uxs = shrink_toward_zero(ux, s);
    uys = shrink_toward_zero(uy, s);
    vxs = shrink_toward_zero(vx, s);
    vys = shrink_toward_zero(vy, s);
    js = uxs * vys - uys * vxs;
    wx = 2 * vxs - uxs;
    wy = 2 * vys - uys;
    ts = 64'd3 * (64'(uxs * uxs) + 64'(uys * uys)) + 64'(wx * wx) + 64'(wy * wy);
    jn = (js > 0) ? 64'(js) : 64'd0;
    while (ts >= ONE30) begin
      ts = ts >> 1;
      jn = jn >> 1;
    end
    if (jn > ts) jn = ts;
    r = (ts != 0) ? (RATIO * jn) / ts : 64'd0;
    if (r > ONE30) r = ONE30;
    d = ONE30 - r;
    return (d * d) >> (60 - tmqc_pkg::FRAC_BITS);
  endfunction

  // folds one triangle into the node state; pushes the node cost on the last one
  task automatic accumulate_triangle(tri_item_t t);
    logic [63:0]  c, avg, idx, res;
    logic         sat;
    node_result_t nr;
    c = triangle_cost(t.xy, sat);
    if (sat) node_sat = 1'b1;
    if (node_count < 64'(NODE_LIMIT)) begin
      node_count++;
      if (c > node_max) node_max = c;
      node_sum += c;
      if (node_sum > ((64'd1 << 48) - 1)) begin
        node_sum = (64'd1 << 48) - 1;
        node_sat = 1'b1;
      end
    end else begin
      node_sat = 1'b1;
    end
    if (!t.last) return;
    if (node_max > 64'(tmqc_pkg::COST_ONE)) begin
      res = node_max;
    end else begin
      avg = node_sum / ((node_count != 0) ? node_count : 64'd1);
      idx = (node_max * 64'(tmqc_pkg::TANH_ENTRIES - 1)
             + (64'd1 << (tmqc_pkg::FRAC_BITS - 1))) >> tmqc_pkg::FRAC_BITS;
      if (idx >= 64'(tmqc_pkg::TANH_ENTRIES)) idx = 64'(tmqc_pkg::TANH_ENTRIES - 1);
      if (avg > node_max) avg = node_max;
      res = avg + ((blend_lut[idx] * (node_max - avg)) >> 30);
    end
    nr.cost = res[31:0];
    nr.sat  = node_sat;
    node_cost_q.push_back(nr);
    node_max   = 0;
    node_sum   = 0;
    node_count = 0;
    node_sat   = 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    n_errors++;
  endtask

  function automatic int sender_idle_pct();
    if (n_accepted < 300) return 11;
    if (n_accepted < 600) return 51;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (n_accepted < 300) return 51;
    if (n_accepted < 600) return 11;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        accumulate_triangle(cur_tri);
        n_accepted++;
        nv = 1'b0;
      end
      if (!nv && tri_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()
          && (!tri_q[0].drain || node_cost_q.size() == 0)) begin
        cur_tri = tri_q.pop_front();
        in_corner0_x     <= cur_tri.xy[0];
        in_corner0_y     <= cur_tri.xy[1];
        in_corner1_x     <= cur_tri.xy[2];
        in_corner1_y     <= cur_tri.xy[3];
        in_corner2_x     <= cur_tri.xy[4];
        in_corner2_y     <= cur_tri.xy[5];
        in_last_triangle <= cur_tri.last;
        nv = 1'b1;
      end
      in_valid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    node_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (node_cost_q.size() == 0) begin
          report_mismatch("unexpected node result", out_node_cost, 32'd0);
        end else begin
          want = node_cost_q.pop_front();
          if (out_node_cost !== want.cost)
            report_mismatch("node_cost", out_node_cost, want.cost);
          if (out_cost_saturated !== want.sat)
            report_mismatch("cost_saturated", 32'(out_cost_saturated), 32'(want.sat));
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || stim_done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic tri_item_t make_tri(logic [31:0] c0x, logic [31:0] c0y,
                                         logic [31:0] c1x, logic [31:0] c1y,
                                         logic [31:0] c2x, logic [31:0] c2y, logic last);
    tri_item_t t;
    t.drain = 1'b0;
    t.last  = last;
    t.xy    = {c2y, c2x, c1y, c1x, c0y, c0x};
    return t;
  endfunction

  // well-formed triangle near equilateral, or flipped, or collinear, or pure noise
  function automatic tri_item_t random_tri(logic last);
    int          kind, bx, by, side, h, jx, jy, k;
    logic [31:0] r[6];
    kind = $urandom_range(99);
    bx   = $signed($urandom) >>> $urandom_range(31, 8);
    by   = $signed($urandom) >>> $urandom_range(31, 8);
    side = $urandom_range(1, 1 << $urandom_range(1, 21));
    h    = (side * 887) / 1024;
    jx   = $signed($urandom_range(0, side / 4 + 1)) - side / 8;
    jy   = $signed($urandom_range(0, side / 4 + 1)) - side / 8;
    if (kind < 55)
      return make_tri(bx + side / 2 + jx, by + h + jy, bx, by, bx + side, by, last);
    if (kind < 72)
      return make_tri(bx + side, by, bx, by, bx + side / 2 + jx, by + h + jy, last);
    if (kind < 80) begin
      k = $urandom_range(0, 3);
      return make_tri(bx + k * side, by + k * jy, bx, by, bx + side, by + jy, last);
    end
    foreach (r[i]) r[i] = $urandom;
    return make_tri(r[0], r[1], r[2], r[3], r[4], r[5], last);
  endfunction

  task automatic add_node(int n_tri);
    for (int i = 0; i < n_tri; i++) tri_q.push_back(random_tri(i == n_tri - 1));
  endtask

  initial begin
    tri_item_t t;
    int        n;
    int        drains;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    {in_corner0_x, in_corner0_y, in_corner1_x, in_corner1_y} = '0;
    {in_corner2_x, in_corner2_y, in_last_triangle} = '0;
    node_max = 0; node_sum = 0; node_count = 0; node_sat = 1'b0;
    n_accepted = 0; n_errors = 0; idle_cycles = 0; stim_done = 1'b0;
    drains = 0;
    fill_blend_lut();

    // coincident corners: zero area
    tri_q.push_back(make_tri(0, 0, 0, 0, 0, 0, 1'b1));
    // unit equilateral-ish and its mirror in one node
    tri_q.push_back(make_tri(32'h8000, 32'hDDB4, 0, 0, 32'h10000, 0, 1'b0));
    tri_q.push_back(make_tri(32'h10000, 0, 0, 0, 32'h8000, 32'hDDB4, 1'b1));
    // extreme corners, both windings, then collinear: the negative area saturates the cost
    tri_q.push_back(make_tri(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h7FFFFFFF, 1'b1));
    tri_q.push_back(make_tri(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                             32'h7FFFFFFF, 32'h80000000, 1'b1));
    tri_q.push_back(make_tri(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             32'h80000000, 32'h80000000, 1'b1));
    // long thin positive triangle: scaling leaves no area
    tri_q.push_back(make_tri(32'h7FFFFFFF, 32'h00000001, 32'h80000000, 0,
                             32'h7FFFFFFF, 0, 1'b1));
    // small triangle blended alone; flipped ones but the 3rd, the first costing just over one
    tri_q.push_back(make_tri(0, 32'h100, 0, 0, 32'h100, 0, 1'b1));
    tri_q.push_back(make_tri(32'h100, 0, 0, 0, 0, 32'h100, 1'b0));
    tri_q.push_back(make_tri(32'h8000, 32'hDDB4, 0, 0, 32'h10000, 0, 1'b1));
    tri_q.push_back(make_tri(32'h1, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
    tri_q.push_back(make_tri(32'h80000000, 32'h7FFFFFFF, 0, 0, 32'hFFFFFFFF, 0, 1'b1));

    n = 0;
    while (n < 850) begin
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      add_node(len);
      n += len;
      if (drains < 2 && n >= 300 * (drains + 1)) begin
        // wait for every node cost before the next item
        t = random_tri(1'b1);
        t.drain = 1'b1;
        tri_q.push_back(t);
        n++;
        drains++;
      end
    end
    add_node(3);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (tri_q.size() != 0 || in_valid || node_cost_q.size() != 0) @(posedge clk);
    stim_done = 1'b1;
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tmqc_pkg.sv
hdl/tmqc_dp.sv
hdl/tmqc_ctrl.sv
hdl/triangle_mesh_quality_cost_unit.sv
hdl/tmqc_checker.sv
tb/tb_top.sv
